// ===== src/macd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macd_pkg
// Shared widths, register codes, controller state and command types.
// ----------------------------------------------------------------------------
package macd_pkg;

  localparam int SIGNAL_MAX  = 64;
  localparam int PTR_W       = $clog2(SIGNAL_MAX);
  localparam int LEN_W       = 7;
  localparam int PRICE_W     = 32;
  localparam int ALPHA_W     = 17;
  localparam int MACD_W      = 33;
  localparam int HIST_W      = 34;
  localparam int SUM_W       = 39;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] CFG_FAST_ALPHA    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_ALPHA    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGNAL_LENGTH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGNAL_RECIP  = 3'd3;

  localparam logic [ALPHA_W-1:0] FAST_ALPHA_RST    = 17'd10082;
  localparam logic [ALPHA_W-1:0] SLOW_ALPHA_RST    = 17'd4855;
  localparam logic [LEN_W-1:0]   SIGNAL_LENGTH_RST = 7'd9;
  localparam logic [ALPHA_W-1:0] SIGNAL_RECIP_RST  = 17'd7282;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WINDOW,
    S_SCALE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic window;
    logic scale;
    logic finish;
  } cmd_t;

endpackage

// ===== src/macd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macd_if
// Valid/ready channels for price items and result items.
// ----------------------------------------------------------------------------
interface macd_sample_if;
  logic                          valid;
  logic                          ready;
  logic [macd_pkg::PRICE_W-1:0]  price;
  logic                          restart;

  modport source (output valid, output price, output restart, input ready);
  modport sink   (input valid, input price, input restart, output ready);
endinterface

interface macd_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [macd_pkg::HIST_W-1:0] histogram;
  logic signed [macd_pkg::MACD_W-1:0] macd_value;
  logic signed [macd_pkg::MACD_W-1:0] signal_value;
  logic                              signal_ready;

  modport source (output valid, output histogram, output macd_value,
                  output signal_value, output signal_ready, input ready);
  modport sink   (input valid, input histogram, input macd_value,
                  input signal_value, input signal_ready, output ready);
endinterface

// ===== src/macd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macd_ctrl
// Sequencer: accept, window update, signal scale, result load.
// ----------------------------------------------------------------------------
module macd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output macd_pkg::cmd_t  cmd
);

  macd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= macd_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      macd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = macd_pkg::S_WINDOW;
        end
      end
      macd_pkg::S_WINDOW: begin
        cmd.window = 1'b1;
        state_next = macd_pkg::S_SCALE;
      end
      macd_pkg::S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = macd_pkg::S_FINISH;
      end
      macd_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = macd_pkg::S_IDLE;
        end
      end
      default: state_next = macd_pkg::S_IDLE;
    endcase
  end

  a_load_then_window: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.window)
    else $error("window step did not follow accept");

  a_scale_then_finish_state: assert property (@(posedge clk) disable iff (rst)
    cmd.scale |=> state == macd_pkg::S_FINISH)
    else $error("scale step not followed by finish state");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.window, cmd.scale, cmd.finish}))
    else $error("more than one datapath command");

endmodule

// ===== src/macd_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macd_dp
// EMA update, MACD ring with running sum, signal scaling, result register.
// ----------------------------------------------------------------------------
module macd_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  macd_pkg::cmd_t                         cmd,
  input  logic                                   cfg_we,
  input  logic [macd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [macd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic [macd_pkg::PRICE_W-1:0]           price,
  input  logic                                   restart,
  output logic signed [macd_pkg::HIST_W-1:0]     histogram,
  output logic signed [macd_pkg::MACD_W-1:0]     macd_value,
  output logic signed [macd_pkg::MACD_W-1:0]     signal_value,
  output logic                                   signal_ready
);

  localparam int PROD_W = macd_pkg::SUM_W + macd_pkg::ALPHA_W + 1;
  localparam int SIGF_W = PROD_W - 16;
  localparam logic signed [SIGF_W-1:0] SIG_HI = SIGF_W'(64'sd4294967295);
  localparam logic signed [SIGF_W-1:0] SIG_LO = SIGF_W'(-64'sd4294967295);

  function automatic logic [macd_pkg::PRICE_W-1:0] ema_step(
    input logic [macd_pkg::PRICE_W-1:0] avg,
    input logic [macd_pkg::PRICE_W-1:0] px,
    input logic [macd_pkg::ALPHA_W-1:0] alpha
  );
    logic signed [macd_pkg::PRICE_W:0]                      d;
    logic signed [macd_pkg::PRICE_W+macd_pkg::ALPHA_W+1:0]  p;
    logic signed [macd_pkg::PRICE_W+4:0]                    r;
    d = $signed({1'b0, px}) - $signed({1'b0, avg});
    p = d * $signed({1'b0, alpha});
    r = $signed({5'b0, avg}) + (macd_pkg::PRICE_W+5)'(p >>> 16);
    if (r < 0) begin
      ema_step = '0;
    end else if (r[macd_pkg::PRICE_W+4:macd_pkg::PRICE_W] != '0) begin
      ema_step = '1;
    end else begin
      ema_step = r[macd_pkg::PRICE_W-1:0];
    end
  endfunction

  logic [macd_pkg::ALPHA_W-1:0] fast_alpha, slow_alpha, signal_recip;
  logic [macd_pkg::LEN_W-1:0]   signal_length, len_eff;

  logic [macd_pkg::PRICE_W-1:0]      fast_average, slow_average;
  logic signed [macd_pkg::SUM_W-1:0] window_sum, window_sum_next;
  logic [macd_pkg::LEN_W-1:0]        seen_count;
  logic [macd_pkg::PTR_W-1:0]        ring_pointer, ptr_eff, ptr_next;
  logic [macd_pkg::LEN_W-1:0]        ptr_inc;
  logic                              full;

  logic signed [macd_pkg::MACD_W-1:0] macd_ring [macd_pkg::SIGNAL_MAX];
  logic signed [macd_pkg::MACD_W-1:0] ring_rd, macd_now, macd_q;
  logic signed [PROD_W-1:0]           prod_q;
  logic                               ready_q;
  logic signed [SIGF_W-1:0]           sig_full;
  logic signed [macd_pkg::MACD_W-1:0] sig_sat;

  always_comb begin
    if (signal_length == '0) begin
      len_eff = macd_pkg::LEN_W'(1);
    end else if (signal_length > macd_pkg::LEN_W'(macd_pkg::SIGNAL_MAX)) begin
      len_eff = macd_pkg::LEN_W'(macd_pkg::SIGNAL_MAX);
    end else begin
      len_eff = signal_length;
    end
    ptr_eff = ({1'b0, ring_pointer} >= len_eff) ? '0 : ring_pointer;
    if (restart) begin
      ptr_eff = '0;
    end
    ptr_inc  = {1'b0, ring_pointer} + macd_pkg::LEN_W'(1);
    ptr_next = (ptr_inc >= len_eff) ? '0 : ptr_inc[macd_pkg::PTR_W-1:0];
    full     = seen_count >= len_eff;
    macd_now = $signed({1'b0, fast_average}) - $signed({1'b0, slow_average});
    window_sum_next = window_sum + macd_pkg::SUM_W'(macd_now)
                    - (full ? macd_pkg::SUM_W'(ring_rd) : '0);
    sig_full = SIGF_W'(prod_q >>> 16);
    if (sig_full > SIG_HI) begin
      sig_sat = macd_pkg::MACD_W'(SIG_HI);
    end else if (sig_full < SIG_LO) begin
      sig_sat = macd_pkg::MACD_W'(SIG_LO);
    end else begin
      sig_sat = macd_pkg::MACD_W'(sig_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_alpha    <= macd_pkg::FAST_ALPHA_RST;
      slow_alpha    <= macd_pkg::SLOW_ALPHA_RST;
      signal_length <= macd_pkg::SIGNAL_LENGTH_RST;
      signal_recip  <= macd_pkg::SIGNAL_RECIP_RST;
      fast_average  <= '0;
      slow_average  <= '0;
      window_sum    <= '0;
      seen_count    <= '0;
      ring_pointer  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          macd_pkg::CFG_FAST_ALPHA: fast_alpha <= cfg_wdata;
          macd_pkg::CFG_SLOW_ALPHA: slow_alpha <= cfg_wdata;
          macd_pkg::CFG_SIGNAL_LENGTH: begin
            signal_length <= cfg_wdata[macd_pkg::LEN_W-1:0];
            window_sum    <= '0;
            seen_count    <= '0;
            ring_pointer  <= '0;
          end
          macd_pkg::CFG_SIGNAL_RECIP: signal_recip <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        ring_pointer <= ptr_eff;
        if (restart) begin
          fast_average <= price;
          slow_average <= price;
          window_sum   <= '0;
          seen_count   <= '0;
        end else begin
          fast_average <= ema_step(fast_average, price, fast_alpha);
          slow_average <= ema_step(slow_average, price, slow_alpha);
        end
      end
      if (cmd.window) begin
        window_sum   <= window_sum_next;
        ring_pointer <= ptr_next;
        if (!full) begin
          seen_count <= seen_count + macd_pkg::LEN_W'(1);
        end
      end
    end
  end

  // ring: one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ring_rd <= macd_ring[ptr_eff];
    end
    if (cmd.window) begin
      macd_ring[ring_pointer] <= macd_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.window) begin
      macd_q <= macd_now;
    end
    if (cmd.scale) begin
      prod_q  <= window_sum * $signed({1'b0, signal_recip});
      ready_q <= full;
    end
    if (cmd.finish) begin
      macd_value   <= macd_q;
      signal_ready <= ready_q;
      signal_value <= ready_q ? sig_sat : '0;
      histogram    <= ready_q ? (macd_pkg::HIST_W'(macd_q) - macd_pkg::HIST_W'(sig_sat)) : '0;
    end
  end

  a_ptr_in_window: assert property (@(posedge clk) disable iff (rst)
    cmd.window |-> {1'b0, ring_pointer} < len_eff)
    else $error("ring pointer outside window");

  a_seen_bounded: assert property (@(posedge clk) disable iff (rst)
    seen_count <= macd_pkg::LEN_W'(macd_pkg::SIGNAL_MAX))
    else $error("seen count above window maximum");

  a_restart_seeds: assert property (@(posedge clk) disable iff (rst)
    cmd.load && restart |=> fast_average == slow_average && seen_count == '0)
    else $error("restart did not seed averages");

endmodule

// ===== src/macd_histogram_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macd_histogram_top
// MACD, signal line and histogram over a stream of Q16.16 prices.
// ----------------------------------------------------------------------------
// A result becomes valid after its item passes the window, scale and finish
// states; finish waits while a result is unaccepted. Items run one at a time
// through accept/window/scale/load, around the single-port MACD ring.
// Reset (rst, synchronous): registers to defaults, averages and window
// cleared, no result pending; the ring needs no clearing pass.
// ----------------------------------------------------------------------------
module macd_histogram_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [macd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [macd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  macd_sample_if.sink                         sample,
  macd_result_if.source                       result
);

  macd_pkg::cmd_t cmd;

  macd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  macd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .price        (sample.price),
    .restart      (sample.restart),
    .histogram    (result.histogram),
    .macd_value   (result.macd_value),
    .signal_value (result.signal_value),
    .signal_ready (result.signal_ready)
  );

endmodule
